>>> hw/rtl/ccfp_pkg.sv
// ----------------------------------------------------------------------------
// ccfp_pkg
// Shared types and constants for the console command frame parser: frame
// marker bytes, hunt phase codes, console status codes and the beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfp_pkg;

  // frame marker bytes
  localparam logic [7:0] HDR_FIRST  = 8'hf3;
  localparam logic [7:0] HDR_SECOND = 8'hd7;
  localparam logic [7:0] TAIL_FIRST = 8'h0d;
  localparam logic [7:0] TAIL_LAST  = 8'h0a;

  // page and command codes
  localparam logic [7:0] PAGE_CTRL  = 8'h01;
  localparam logic [7:0] PAGE_SHOP  = 8'h02;
  localparam logic [7:0] CMD_ONE    = 8'h01;
  localparam logic [7:0] CMD_TWO    = 8'h02;
  localparam logic [7:0] CMD_THREE  = 8'h03;

  // hunt phase codes (the unused code behaves as hunting)
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;

  // body byte positions
  localparam logic [2:0] POS_PAGE   = 3'd0;
  localparam logic [2:0] POS_CMD    = 3'd1;
  localparam logic [2:0] POS_TAIL0  = 3'd4;
  localparam logic [2:0] POS_TAIL1  = 3'd5;

  // console status codes
  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_RUNNING = 3'd1;
  localparam logic [2:0] ST_PAUSED  = 3'd2;
  localparam logic [2:0] ST_MANAGE  = 3'd3;
  localparam logic [2:0] ST_QUERY   = 3'd4;
  localparam logic [2:0] ST_BUY     = 3'd5;

  // completed frame seen by the framer
  typedef struct packed {
    logic       done;
    logic       tail_ok;
    logic [7:0] page;
    logic [7:0] command;
  } frame_event_t;

  // one result beat
  typedef struct packed {
    logic       tail_error;
    logic [2:0] console_status;
    logic [7:0] page_number;
    logic [7:0] command_number;
    logic       resume_pulse;
    logic       pause_pulse;
    logic       query_request;
    logic       buy_request;
  } frame_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ccfp_framer.sv
// ----------------------------------------------------------------------------
// ccfp_framer
// Header hunt and body collection. Tracks the hunt phase and body position,
// holds page and command bytes and reports each completed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfp_framer import ccfp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         process,
  input  wire logic [7:0]   rx_byte,
  output frame_event_t      frame_event
);

  logic [1:0] hunt_phase;
  logic [1:0] hunt_phase_next;
  logic [2:0] body_count;
  logic [2:0] body_count_next;
  logic [2:0] body_count_inc;
  logic [7:0] held_page;
  logic [7:0] held_command;
  logic       first_tail_ok;

  assign body_count_inc = body_count + 3'd1;

  // phase and position update for the byte being processed
  always_comb begin
    hunt_phase_next = hunt_phase;
    body_count_next = body_count;
    case (hunt_phase)
      PH_SECOND: begin
        if (rx_byte == HDR_SECOND) begin
          hunt_phase_next = PH_BODY;
          body_count_next = 3'd0;
        end else if (rx_byte == HDR_FIRST) begin
          hunt_phase_next = PH_SECOND;
        end else begin
          hunt_phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (body_count == POS_TAIL1) begin
          hunt_phase_next = PH_HUNT;
          body_count_next = 3'd0;
        end else if (body_count_inc > POS_TAIL1) begin
          hunt_phase_next = PH_HUNT;
          body_count_next = 3'd0;
        end else begin
          body_count_next = body_count_inc;
        end
      end
      default: begin
        hunt_phase_next = (rx_byte == HDR_FIRST) ? PH_SECOND : PH_HUNT;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_phase    <= PH_HUNT;
      body_count    <= 3'd0;
      held_page     <= 8'd0;
      held_command  <= 8'd0;
      first_tail_ok <= 1'b0;
    end else if (process) begin
      hunt_phase <= hunt_phase_next;
      body_count <= body_count_next;
      if (hunt_phase == PH_BODY) begin
        if (body_count == POS_PAGE) held_page <= rx_byte;
        if (body_count == POS_CMD) held_command <= rx_byte;
        if (body_count == POS_TAIL0) first_tail_ok <= (rx_byte == TAIL_FIRST);
      end
    end
  end

  // frame completes on the last tail byte
  always_comb begin
    frame_event.done    = (hunt_phase == PH_BODY) && (body_count == POS_TAIL1);
    frame_event.tail_ok = first_tail_ok && (rx_byte == TAIL_LAST);
    frame_event.page    = held_page;
    frame_event.command = held_command;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ccfp_status.sv
// ----------------------------------------------------------------------------
// ccfp_status
// Console status register and command table. Turns a completed frame into
// the new status, the resume and pause pulses and the query and buy requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfp_status import ccfp_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          process,
  input  wire frame_event_t  frame_event,
  output frame_result_t      result
);

  logic [2:0] status_code;
  logic [2:0] status_code_next;
  logic       resume;
  logic       pause;

  // command table, applied only for a good tail
  always_comb begin
    status_code_next = status_code;
    resume           = 1'b0;
    pause            = 1'b0;
    if (frame_event.tail_ok) begin
      if (frame_event.page == PAGE_CTRL) begin
        if (frame_event.command == CMD_ONE) begin
          status_code_next = ST_RUNNING;
          resume           = 1'b1;
        end else if (frame_event.command == CMD_TWO) begin
          status_code_next = ST_PAUSED;
          pause            = 1'b1;
        end else if (frame_event.command == CMD_THREE) begin
          status_code_next = ST_MANAGE;
          pause            = 1'b1;
        end
      end else if (frame_event.page == PAGE_SHOP) begin
        if (frame_event.command == CMD_ONE) begin
          status_code_next = ST_QUERY;
        end else if (frame_event.command == CMD_TWO) begin
          status_code_next = ST_BUY;
        end else if (frame_event.command == CMD_THREE) begin
          status_code_next = ST_MANAGE;
          pause            = 1'b1;
        end
      end
    end
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      status_code <= ST_INIT;
    end else if (process && frame_event.done) begin
      status_code <= status_code_next;
    end
  end

  // result fields
  always_comb begin
    result.tail_error     = !frame_event.tail_ok;
    result.console_status = status_code_next;
    result.page_number    = frame_event.page;
    result.command_number = frame_event.command;
    result.resume_pulse   = resume;
    result.pause_pulse    = pause;
    result.query_request  = frame_event.tail_ok && (status_code_next == ST_QUERY);
    result.buy_request    = frame_event.tail_ok && (status_code_next == ST_BUY);
  end

endmodule

`default_nettype wire

>>> hw/rtl/console_command_frame_parser.sv
// ----------------------------------------------------------------------------
// console_command_frame_parser
// Finds eight-byte console command frames in a received byte stream and
// reports each completed frame with the updated console status.
// ----------------------------------------------------------------------------
// Takes one byte per beat and accepts a new byte every cycle while the
// result side keeps up. Each byte goes through an input register, one pass
// of compare-and-update logic and a result register, so a frame result
// is held in the result register once its last tail byte is processed. One result
// beat is produced for each frame of header 0xf3 0xd7, page, command, two
// reserved bytes and a tail; a wrong tail gives a beat with tail_error set and
// leaves the status unchanged. The input stalls only while a byte sits in the
// input register, a result waits in the result register and the output is
// stalled.
`default_nettype none

module console_command_frame_parser import ccfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            frame_valid,
  input  wire logic       frame_stall,
  output logic            tail_error,
  output logic [2:0]      console_status,
  output logic [7:0]      page_number,
  output logic [7:0]      command_number,
  output logic            resume_pulse,
  output logic            pause_pulse,
  output logic            query_request,
  output logic            buy_request
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;
  logic          process;
  frame_event_t  frame_event;
  frame_result_t result;
  frame_result_t result_reg;

  // pipeline moves when the result register is free or being taken
  assign advance  = !frame_valid || !frame_stall;
  assign process  = in_valid && advance;
  assign rx_stall = in_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!rx_stall) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) in_byte <= rx_byte;
  end

  ccfp_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .process     (process),
    .rx_byte     (in_byte),
    .frame_event (frame_event)
  );

  ccfp_status u_status (
    .clk         (clk),
    .rst         (rst),
    .process     (process),
    .frame_event (frame_event),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= process && frame_event.done;
    end
  end

  always_ff @(posedge clk) begin
    if (process && frame_event.done) result_reg <= result;
  end

  assign tail_error     = result_reg.tail_error;
  assign console_status = result_reg.console_status;
  assign page_number    = result_reg.page_number;
  assign command_number = result_reg.command_number;
  assign resume_pulse   = result_reg.resume_pulse;
  assign pause_pulse    = result_reg.pause_pulse;
  assign query_request  = result_reg.query_request;
  assign buy_request    = result_reg.buy_request;

`ifndef SYNTHESIS
  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> (frame_valid && frame_stall))
    else $error("input stalled without a blocked result");

  // a dropped frame carries no pulse or request
  a_bad_tail_quiet: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && tail_error) |->
      !(resume_pulse || pause_pulse || query_request || buy_request))
    else $error("pulse or request on a dropped frame");

  // requests follow the reported status
  a_request_status: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && (query_request || buy_request)) |->
      ((query_request && console_status == ST_QUERY) ||
       (buy_request && console_status == ST_BUY)))
    else $error("request does not match status");

  // resume and pause never together
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> !(resume_pulse && pause_pulse))
    else $error("resume and pause pulses together");
`endif

endmodule

`default_nettype wire
